// ----- rtl/core/slrd_pkg.sv -----
`default_nettype none

package slrd_pkg;

  // Field and register widths
  localparam int DIM_W  = 13;
  localparam int SIZE_W = 24;
  localparam int POS_W  = 2 * DIM_W;
  localparam int ADDR_W = 24;
  localparam int ADDRESS_WIDTH_DEFAULT = 24;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]  SCREEN_HEIGHT_RESET = 13'd480;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET    = 24'd0;

  // Result status codes
  localparam logic [1:0] STATUS_RUN   = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // Block layout
  localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = 24'd10;
  localparam logic [SIZE_W-1:0] COL_LAST_BYTE  = 24'd3;
  localparam logic [SIZE_W-1:0] ROW_LAST_BYTE  = 24'd7;
  localparam logic [15:0]       RUN_LEN_MASK   = 16'h7FFF;
  localparam logic [15:0]       LITERAL_FLAG   = 16'h8000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        pixel_value;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]  screen_width;
    logic [DIM_W-1:0]  screen_height;
    logic [SIZE_W-1:0] block_size;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/slrd_cfg.sv -----
`default_nettype none

module slrd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [slrd_pkg::SIZE_W-1:0] cfg_data,
  output slrd_pkg::cfg_t                  cfg
);
  import slrd_pkg::*;

  // Always able to take a register write
  assign cfg_ready = 1'b1;

  // Store the addressed register, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SCREEN_WIDTH_RESET;
      cfg.screen_height <= SCREEN_HEIGHT_RESET;
      cfg.block_size    <= BLOCK_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[DIM_W-1:0];
        CFG_BLOCK_SIZE:    cfg.block_size    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slrd_core.sv -----
`default_nettype none

module slrd_core #(
  parameter int ADDRESS_WIDTH = slrd_pkg::ADDRESS_WIDTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire slrd_pkg::item_t item,
  input  wire slrd_pkg::cfg_t  cfg,
  input  wire logic            room,
  output logic                 push,
  output slrd_pkg::result_t    push_data
);
  import slrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FLAG_LO,
    PH_FLAG_HI,
    PH_LITERAL
  } phase_t;

  // Input register
  logic  ivalid;
  item_t ipay;

  // Parse state
  phase_t            phase, phase_next;
  logic [SIZE_W-1:0] bytes_seen, bytes_seen_next;
  logic [31:0]       header_word, header_word_next;
  logic [31:0]       start_column, start_column_next;
  logic [7:0]        flag_low_byte, flag_low_byte_next;
  logic [POS_W-1:0]  write_position, write_position_next;
  logic [14:0]       run_left, run_left_next;
  logic              block_finished, block_finished_next;

  logic              fire;
  logic [SIZE_W-1:0] pos, seen_inc, left;
  logic [31:0]       hw_new;
  logic              start_bad;
  logic [POS_W-1:0]  start_pos, screen, room_left, amask;
  logic [15:0]       flag;
  logic [14:0]       count, run_dec;
  phase_t            ph_eff;
  logic              stop, wrote;

  assign fire       = ivalid && room;
  assign item_stall = ivalid && !room;

  // Datapath terms shared by the phases
  always_comb begin
    pos       = ipay.first_byte ? '0 : bytes_seen;
    seen_inc  = pos + 24'd1;
    hw_new    = (ipay.first_byte ? 32'd0 : header_word) |
                ({24'd0, ipay.data_byte} << {pos[1:0], 3'b000});
    start_bad = start_column[31] || hw_new[31] ||
                (start_column >= {19'd0, cfg.screen_width}) ||
                (hw_new >= {19'd0, cfg.screen_height});
    start_pos = {13'd0, hw_new[DIM_W-1:0]} * {13'd0, cfg.screen_width} +
                {13'd0, start_column[DIM_W-1:0]};
    screen    = {13'd0, cfg.screen_width} * {13'd0, cfg.screen_height};
    room_left = (screen > write_position) ? screen - write_position : '0;
    left      = (cfg.block_size > seen_inc) ? cfg.block_size - seen_inc : '0;
    flag      = {ipay.data_byte, flag_low_byte};
    count     = flag[14:0] & RUN_LEN_MASK[14:0];
    run_dec   = run_left - 15'd1;
    ph_eff    = ipay.first_byte ? PH_HEADER : phase;
    for (int i = 0; i < POS_W; i++) begin
      amask[i] = (i < ADDRESS_WIDTH);
    end
  end

  // Advance the parse by one byte
  always_comb begin
    phase_next          = phase;
    bytes_seen_next     = bytes_seen;
    header_word_next    = header_word;
    start_column_next   = start_column;
    flag_low_byte_next  = flag_low_byte;
    write_position_next = write_position;
    run_left_next       = run_left;
    block_finished_next = block_finished;
    push                = 1'b0;
    push_data           = '0;
    stop                = 1'b0;
    wrote               = 1'b0;

    if (fire) begin
      if (ipay.first_byte && cfg.block_size < MIN_BLOCK_SIZE) begin
        // Block too short: abandon at once
        bytes_seen_next     = '0;
        header_word_next    = '0;
        run_left_next       = '0;
        block_finished_next = 1'b1;
        phase_next          = PH_IDLE;
        push                = 1'b1;
        push_data.status    = STATUS_ERROR;
      end else if (ipay.first_byte || !block_finished) begin
        bytes_seen_next     = seen_inc;
        block_finished_next = 1'b0;
        phase_next          = ph_eff;
        if (ipay.first_byte) begin
          header_word_next = '0;
          run_left_next    = '0;
        end
        case (ph_eff)
          PH_HEADER: begin
            header_word_next = hw_new;
            if (pos == COL_LAST_BYTE) begin
              start_column_next = hw_new;
              header_word_next  = '0;
            end else if (pos == ROW_LAST_BYTE) begin
              if (start_bad) begin
                stop             = 1'b1;
                push_data.status = STATUS_ERROR;
              end else begin
                write_position_next = start_pos;
                phase_next          = PH_FLAG_LO;
              end
            end
          end
          PH_FLAG_LO: begin
            flag_low_byte_next = ipay.data_byte;
            phase_next         = PH_FLAG_HI;
          end
          PH_FLAG_HI: begin
            if (flag == 16'd0) begin
              stop             = 1'b1;
              push_data.status = STATUS_DONE;
            end else if ({11'd0, count} > room_left) begin
              stop             = 1'b1;
              push_data.status = STATUS_ERROR;
            end else if ((flag & LITERAL_FLAG) != 16'd0) begin
              if ({9'd0, count} > left) begin
                stop             = 1'b1;
                push_data.status = STATUS_ERROR;
              end else if (count != 15'd0) begin
                run_left_next = count;
                phase_next    = PH_LITERAL;
              end else begin
                phase_next = PH_FLAG_LO;
              end
            end else begin
              write_position_next = write_position + {11'd0, count};
              phase_next          = PH_FLAG_LO;
            end
          end
          PH_LITERAL: begin
            wrote                   = 1'b1;
            push_data.write_enable  = 1'b1;
            push_data.pixel_address = ADDR_W'(write_position & amask);
            push_data.pixel_value   = ipay.data_byte;
            write_position_next     = write_position + 26'd1;
            run_left_next           = run_dec;
            if (run_dec == 15'd0) begin
              phase_next = PH_FLAG_LO;
            end
          end
          default: begin
            stop             = 1'b1;
            push_data.status = STATUS_ERROR;
          end
        endcase

        // Close the block on a verdict or when the byte count runs out
        if (stop) begin
          block_finished_next = 1'b1;
          phase_next          = PH_IDLE;
          push                = 1'b1;
        end else if (seen_inc >= cfg.block_size) begin
          block_finished_next = 1'b1;
          phase_next          = PH_IDLE;
          push                = 1'b1;
          push_data.status    = STATUS_ERROR;
        end else begin
          push             = wrote;
          push_data.status = STATUS_RUN;
        end
      end
    end
  end

  // Hold input beat and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid         <= 1'b0;
      phase          <= PH_IDLE;
      bytes_seen     <= '0;
      header_word    <= '0;
      start_column   <= '0;
      flag_low_byte  <= '0;
      write_position <= '0;
      run_left       <= '0;
      block_finished <= 1'b1;
    end else begin
      if (!item_stall) begin
        ivalid <= item_valid;
      end
      phase          <= phase_next;
      bytes_seen     <= bytes_seen_next;
      header_word    <= header_word_next;
      start_column   <= start_column_next;
      flag_low_byte  <= flag_low_byte_next;
      write_position <= write_position_next;
      run_left       <= run_left_next;
      block_finished <= block_finished_next;
    end
    if (!item_stall) begin
      ipay <= item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slrd_outbuf.sv -----
`default_nettype none

module slrd_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire slrd_pkg::result_t push_data,
  output logic                   room,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output slrd_pkg::result_t      result
);
  import slrd_pkg::*;

  // Skid entry behind the output register
  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign room = !skid_valid;
  assign pop  = result_valid && !result_stall;

  // Fill the output register first, spill into the skid entry when it is held
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      if (!result_valid || pop) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
    if (push) begin
      if (!result_valid || pop) begin
        result <= push_data;
      end else begin
        skid <= push_data;
      end
    end else if (pop) begin
      result <= skid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/skip_literal_run_decoder_unit.sv -----
`default_nettype none

// Skip/literal run decoder. Takes one byte of a run-coded overlay block per beat on
// the item channel (first_byte restarts the parse) and gives a result beat for every
// literal pixel write and one when the block ends, with status 1 on the zero
// terminator and 2 on any error. Other header and run-word bytes give no result,
// and bytes after the end are dropped until the next first byte. One byte is taken
// every cycle while the output buffer has room; a result passes the input register
// and one update of the parse state before it reaches the output register.
// A two-entry output buffer lets the input run on while one result waits.
// Registers (screen width, screen height, block size) are to be written on the cfg
// channel only while the block is idle; the block itself does not enforce this.
module skip_literal_run_decoder_unit #(
  parameter int ADDRESS_WIDTH = slrd_pkg::ADDRESS_WIDTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire slrd_pkg::item_t             item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output slrd_pkg::result_t                result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [slrd_pkg::SIZE_W-1:0] cfg_data
);
  import slrd_pkg::*;

  cfg_t    cfg;
  logic    room;
  logic    push;
  result_t push_data;

  slrd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slrd_core #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .room       (room),
    .push       (push),
    .push_data  (push_data)
  );

  slrd_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // A beat without a pixel write always closes the block
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_enable |-> result.status != STATUS_RUN)
    else $error("result without write carries running status");

  // A beat without a pixel write carries a cleared address and value
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.write_enable |->
      result.pixel_address == '0 && result.pixel_value == 8'd0)
    else $error("non-write result carries pixel data");

  // The input holds only while the output buffer is backed up
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && $past(result_valid))
    else $error("input stalled with output buffer not full");
`endif

endmodule

`default_nettype wire
